[hdl/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed partition allocator package
// Field widths, operation codes and result status codes shared by the core
// and its port checker.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FUNC_W   = 2;
    localparam int PID_W    = 16;
    localparam int SIZE_W   = 32;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 40;

    // s_axis_tdata: process_id, req_size, part_index
    localparam int S_TDATA_W = 56;
    // m_axis_tdata: chosen_partition, owner_id, internal_frag, total_frag
    localparam int M_TDATA_W = 96;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_func FN_LOAD    = 2'd0;
    localparam t_func FN_ALLOC   = 2'd1;
    localparam t_func FN_RELEASE = 2'd2;
    localparam t_func FN_CLEAR   = 2'd3;

    localparam t_status ST_ALLOCATED    = 3'd0;
    localparam t_status ST_NO_FIT       = 3'd1;
    localparam t_status ST_RELEASED     = 3'd2;
    localparam t_status ST_ALREADY_FREE = 3'd3;
    localparam t_status ST_BAD_INDEX    = 3'd4;
    localparam t_status ST_LOADED       = 3'd5;
    localparam t_status ST_CLEARED      = 3'd6;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

[hdl/fixed_partition_allocator_core.sv]
// ----------------------------------------------------------------------------
// Fixed partition allocator core
// Table of fixed partitions with first fit / best fit placement, release,
// size load, clear and a saturating fragmentation total.
// Sequence: allocate goes dispatch, scan, alloc, accumulate, done (no fit
//   skips accumulate; one size compare per cycle over the table); load, clear,
//   bad index and release of a free partition go dispatch, done; release of a
//   busy partition goes dispatch, release, done. One transaction is in flight
//   at a time; a result may wait in the output register while the next item
//   is taken.
// Reset: synchronous, active low; all partitions free with size zero,
//   total zero, fit mode first fit.
// ----------------------------------------------------------------------------
module fixed_partition_allocator_core #(
    parameter int PARTITIONS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: fit_mode
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data,
    // s_axis_tdata: [15:0] process_id, [47:16] req_size, [55:48] part_index
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [fpa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // s_axis_tuser: [1:0] func
    input  logic [fpa_pkg::FUNC_W-1:0]    s_axis_tuser,
    // m_axis_tdata: [7:0] chosen_partition, [23:8] owner_id,
    //               [55:24] internal_frag, [95:56] total_frag
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [fpa_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // m_axis_tuser: [2:0] status
    output logic [fpa_pkg::STATUS_W-1:0]  m_axis_tuser
);
    import fpa_pkg::*;

    localparam int IW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CW = $clog2(PARTITIONS + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_ALLOC    = 3'd3;
    localparam logic [2:0] S_ACC      = 3'd4;
    localparam logic [2:0] S_REL      = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    // partition table
    logic [SIZE_W-1:0] r_size_mem  [PARTITIONS];
    logic [PID_W-1:0]  r_owner_mem [PARTITIONS];
    logic [PARTITIONS-1:0] r_busy, n_busy;
    logic [PARTITIONS-1:0] r_size_vld, n_size_vld;

    logic [2:0]         r_state, n_state;
    logic               r_fit_mode;
    logic [TOTAL_W-1:0] r_frag_sum, n_frag_sum;

    // latched input item
    t_func             r_func;
    logic [PID_W-1:0]  r_pid;
    logic [SIZE_W-1:0] r_req;
    logic [IDX_W-1:0]  r_pidx;

    // scan
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_rd_vld, n_rd_vld;
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic [SIZE_W-1:0] r_rd_size;
    logic [PID_W-1:0]  r_rd_owner;
    logic              r_rd_free, n_rd_free;
    logic              r_rd_sv, n_rd_sv;
    logic              r_found, n_found;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    logic [SIZE_W-1:0] r_best_size, n_best_size;
    logic [IW-1:0]     rd_addr;

    // result staging
    t_status           r_res_status, n_res_status;
    logic [IDX_W-1:0]  r_res_part, n_res_part;
    logic [PID_W-1:0]  r_res_owner, n_res_owner;
    logic [SIZE_W-1:0] r_res_frag, n_res_frag;

    // output register
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    logic                 in_take;
    logic                 out_take;
    logic                 idx_ok;
    logic [IW-1:0]        pidx_addr;
    logic [SIZE_W-1:0]    cand_size;
    logic                 cand_fits;
    logic                 size_wr;
    logic                 owner_wr;
    logic [TOTAL_W:0]     sum_ext;

    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign out_take  = r_out_valid && m_axis_tready;
    assign idx_ok    = ({1'b0, r_pidx} < (IDX_W + 1)'(PARTITIONS));
    assign pidx_addr = r_pidx[IW-1:0];
    assign cand_size = r_rd_sv ? r_rd_size : '0;
    assign cand_fits = r_rd_vld && r_rd_free && (r_req <= cand_size);
    assign sum_ext   = {1'b0, r_frag_sum} + (TOTAL_W + 1)'(r_res_frag);
    assign size_wr   = (r_state == S_DISPATCH) && (r_func == FN_LOAD) && idx_ok;
    assign owner_wr  = (r_state == S_ALLOC) && r_found;
    assign rd_addr   = (r_state == S_DISPATCH) ? pidx_addr : r_cnt[IW-1:0];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_size_vld   = r_size_vld;
        n_frag_sum   = r_frag_sum;
        n_cnt        = r_cnt;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_cnt[IW-1:0];
        n_rd_free    = !r_busy[rd_addr];
        n_rd_sv      = r_size_vld[rd_addr];
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_size  = r_best_size;
        n_res_status = r_res_status;
        n_res_part   = r_res_part;
        n_res_owner  = r_res_owner;
        n_res_frag   = r_res_frag;
        n_out_valid  = r_out_valid && !out_take;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res_status = ST_CLEARED;
                n_res_part   = '0;
                n_res_owner  = '0;
                n_res_frag   = '0;
                n_state      = S_DONE;
                unique case (r_func)
                    FN_LOAD: begin
                        if (!idx_ok) begin
                            n_res_status = ST_BAD_INDEX;
                        end else begin
                            n_size_vld[pidx_addr] = 1'b1;
                            n_busy[pidx_addr]     = 1'b0;
                            n_res_status          = ST_LOADED;
                            n_res_part            = r_pidx;
                        end
                    end
                    FN_RELEASE: begin
                        if (!idx_ok) begin
                            n_res_status = ST_BAD_INDEX;
                        end else if (r_busy[pidx_addr]) begin
                            // wait for the registered owner read
                            n_res_part = r_pidx;
                            n_state    = S_REL;
                        end else begin
                            n_res_status = ST_ALREADY_FREE;
                            n_res_part   = r_pidx;
                        end
                    end
                    FN_ALLOC: begin
                        n_cnt   = '0;
                        n_found = 1'b0;
                        n_state = S_SCAN;
                    end
                    FN_CLEAR: begin
                        n_frag_sum = '0;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                // issue one read per cycle, compare the previous entry
                if (r_cnt < CW'(PARTITIONS)) begin
                    n_rd_vld = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                end
                if (cand_fits && (!r_found || (r_fit_mode && (cand_size < r_best_size)))) begin
                    n_found     = 1'b1;
                    n_best_idx  = r_rd_idx;
                    n_best_size = cand_size;
                end
                if ((r_cnt == CW'(PARTITIONS)) && !r_rd_vld) begin
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (r_found) begin
                    n_busy[r_best_idx] = 1'b1;
                    n_res_status       = ST_ALLOCATED;
                    n_res_part         = IDX_W'(r_best_idx);
                    n_res_owner        = r_pid;
                    n_res_frag         = r_best_size - r_req;
                    n_state            = S_ACC;
                end else begin
                    n_res_status = ST_NO_FIT;
                    n_state      = S_DONE;
                end
            end
            S_ACC: begin
                // saturate the running total
                n_frag_sum = sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
                n_state    = S_DONE;
            end
            S_REL: begin
                n_busy[pidx_addr] = 1'b0;
                n_res_status      = ST_RELEASED;
                n_res_owner       = r_rd_owner;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || out_take) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = {r_frag_sum, r_res_frag, r_res_owner, r_res_part};
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_size_vld  <= '0;
            r_frag_sum  <= '0;
            r_fit_mode  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_size_vld  <= n_size_vld;
            r_frag_sum  <= n_frag_sum;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
            r_found     <= n_found;
            r_cnt       <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fit_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func <= s_axis_tuser;
            r_pid  <= s_axis_tdata[PID_W-1:0];
            r_req  <= s_axis_tdata[PID_W +: SIZE_W];
            r_pidx <= s_axis_tdata[PID_W + SIZE_W +: IDX_W];
        end
        r_rd_idx     <= n_rd_idx;
        r_rd_free    <= n_rd_free;
        r_rd_sv      <= n_rd_sv;
        r_best_idx   <= n_best_idx;
        r_best_size  <= n_best_size;
        r_res_status <= n_res_status;
        r_res_part   <= n_res_part;
        r_res_owner  <= n_res_owner;
        r_res_frag   <= n_res_frag;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end

    // table memories, registered read
    always_ff @(posedge i_clk) begin
        if (size_wr) begin
            r_size_mem[pidx_addr] <= r_req;
        end
        if (owner_wr) begin
            r_owner_mem[r_best_idx] <= r_pid;
        end
        r_rd_size  <= r_size_mem[rd_addr];
        r_rd_owner <= r_owner_mem[rd_addr];
    end

endmodule

[hdl/fpa_checker.sv]
// ----------------------------------------------------------------------------
// Fixed partition allocator port checker
// Watches the core's ports for stream holding and result consistency.
// ----------------------------------------------------------------------------
module fpa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [fpa_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [fpa_pkg::STATUS_W-1:0]  m_axis_tuser
);
    import fpa_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one transaction at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_CLEARED))
        else $error("undefined status");

    a_frag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_ALLOCATED) |->
            (m_axis_tdata[55:24] == '0))
        else $error("fragmentation on non-allocation");

    a_clear_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_CLEARED) |->
            (m_axis_tdata[95:56] == '0) && (m_axis_tdata[23:0] == '0))
        else $error("clear result not zero");

endmodule

bind fixed_partition_allocator_core fpa_checker u_fpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
